FILE: design/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, constants and character functions of the DOS short-name
// case converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  localparam logic [1:0] CFG_SHORT_MODE = 2'd0;
  localparam logic [1:0] CFG_LONG_MODE  = 2'd1;

  localparam logic [1:0] MODE_UPPER = 2'd1;
  localparam logic [1:0] MODE_LOWER = 2'd2;

  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic bank;
    logic is_short;
    logic trunc;
  } name_info_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5a);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  function automatic logic char_allowed(input logic [7:0] c);
    logic ok;
    case (c) inside
      [8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39]: ok = 1'b1;
      8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h28, 8'h29,
      8'h7e, 8'h60, 8'h27, 8'h2d, 8'h5f, 8'h7b, 8'h7d, 8'h2e: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] convert_case(input logic [7:0] c, input logic [1:0] mode);
    logic [7:0] r;
    r = c;
    if (mode == MODE_UPPER && is_lower(c)) begin
      r = c - CASE_DELTA;
    end else if (mode == MODE_LOWER && is_upper(c)) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/dos_short_name_case_converter_top.sv
// ----------------------------------------------------------------------------
// dos_short_name_case_converter_top
// DOS 8.3 name check with case conversion of the buffered name.
// ----------------------------------------------------------------------------
// Characters enter one per cycle while busy is low. On the item marked last
// the name is classified and queued; the output side then sends one result
// per stored character, one per cycle, on out_valid, through the registered
// buffer read and output register. The receiver cannot stall: each result is
// present for exactly one cycle. The buffer has two banks, so one name can
// be streamed out while the next is taken in; busy rises only when both
// banks hold names waiting to be sent, so the sustained rate is one
// character per cycle, set by the single read port of the name buffer.
// Names longer than MAX_NAME are cut to MAX_NAME and flagged as truncated.
`default_nettype none

module dos_short_name_case_converter_top
  import dsc_pkg::*;
#(
  parameter int MAX_NAME = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] ch,
  input  wire logic       last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data,
  output logic            out_valid,
  output logic [7:0]      out_ch,
  output logic            out_last,
  output logic            is_short_name,
  output logic            truncated
);

  localparam int IW = $clog2(MAX_NAME);
  localparam int LW = $clog2(MAX_NAME + 1);

  logic [1:0]    short_case_mode;
  logic [1:0]    long_case_mode;
  logic          q_full;
  logic          q_empty;
  logic          wr_en;
  logic [IW:0]   wr_addr;
  logic [7:0]    wr_data;
  logic [IW:0]   rd_addr;
  logic [7:0]    rd_data;
  logic          push;
  logic          pop;
  name_info_t    push_info;
  name_info_t    head_info;
  logic [LW-1:0] push_len;
  logic [LW-1:0] head_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_case_mode <= '0;
      long_case_mode  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHORT_MODE: short_case_mode <= cfg_data;
        CFG_LONG_MODE:  long_case_mode  <= cfg_data;
        default: ;
      endcase
    end
  end

  dsc_front #(.MAX_NAME(MAX_NAME), .IW(IW), .LW(LW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .ch        (ch),
    .last      (last),
    .q_full    (q_full),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_info (push_info),
    .push_len  (push_len)
  );

  dsc_name_ram #(.AW(IW + 1)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dsc_info_fifo #(.LW(LW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_info (push_info),
    .push_len  (push_len),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_info (head_info),
    .head_len  (head_len)
  );

  dsc_back #(.IW(IW), .LW(LW)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .head_info       (head_info),
    .head_len        (head_len),
    .rd_data         (rd_data),
    .short_case_mode (short_case_mode),
    .long_case_mode  (long_case_mode),
    .pop             (pop),
    .rd_addr         (rd_addr),
    .out_valid       (out_valid),
    .out_ch          (out_ch),
    .out_last        (out_last),
    .is_short_name   (is_short_name),
    .truncated       (truncated)
  );

endmodule

`default_nettype wire

FILE: design/dsc_front.sv
// ----------------------------------------------------------------------------
// dsc_front
// Accepts name characters, stores them in the free buffer bank and tracks
// the 8.3 checks; on the last character queues a name descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_front
  import dsc_pkg::*;
#(
  parameter int MAX_NAME = 64,
  parameter int IW       = 6,
  parameter int LW       = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [7:0]    ch,
  input  wire logic          last,
  input  wire logic          q_full,
  output logic               busy,
  output logic               wr_en,
  output logic [IW:0]        wr_addr,
  output logic [7:0]         wr_data,
  output logic               push,
  output name_info_t         push_info,
  output logic [LW-1:0]      push_len
);

  logic          wr_bank;
  logic [LW-1:0] fill_count;
  logic [3:0]    base_length;
  logic [2:0]    ext_length;
  logic [1:0]    dot_count;
  logic          saw_upper;
  logic          saw_lower;
  logic          bad_char_seen;
  logic          overflow;

  logic [LW-1:0] fill_count_next;
  logic [3:0]    base_length_next;
  logic [2:0]    ext_length_next;
  logic [1:0]    dot_count_next;
  logic          saw_upper_next;
  logic          saw_lower_next;
  logic          bad_char_seen_next;
  logic          overflow_next;

  logic accept;
  logic fits;
  logic allowed;

  assign busy    = q_full;
  assign accept  = start && !busy;
  assign fits    = fill_count < LW'(MAX_NAME);
  assign allowed = char_allowed(ch);
  assign wr_en   = accept && fits;
  assign wr_addr = {wr_bank, fill_count[IW-1:0]};
  assign wr_data = ch;

  always_comb begin
    base_length_next   = base_length;
    ext_length_next    = ext_length;
    dot_count_next     = dot_count;
    saw_upper_next     = saw_upper;
    saw_lower_next     = saw_lower;
    bad_char_seen_next = bad_char_seen;
    if (!allowed) begin
      bad_char_seen_next = 1'b1;
    end else if (ch == CHAR_DOT) begin
      if (dot_count < 2'd2) dot_count_next = dot_count + 2'd1;
    end else begin
      if (dot_count == 2'd0) begin
        if (base_length < 4'd9) base_length_next = base_length + 4'd1;
      end else begin
        if (ext_length < 3'd4) ext_length_next = ext_length + 3'd1;
      end
      if (is_upper(ch)) saw_upper_next = 1'b1;
      else if (is_lower(ch)) saw_lower_next = 1'b1;
    end
    fill_count_next = fits ? fill_count + LW'(1) : fill_count;
    overflow_next   = overflow || !fits;
  end

  assign push               = accept && last;
  assign push_len           = fill_count_next;
  assign push_info.bank     = wr_bank;
  assign push_info.trunc    = overflow_next;
  assign push_info.is_short = !bad_char_seen_next && (dot_count_next < 2'd2) &&
                              (ext_length_next < 3'd4) && (base_length_next < 4'd9) &&
                              !(saw_upper_next && saw_lower_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_bank       <= 1'b0;
      fill_count    <= '0;
      base_length   <= '0;
      ext_length    <= '0;
      dot_count     <= '0;
      saw_upper     <= 1'b0;
      saw_lower     <= 1'b0;
      bad_char_seen <= 1'b0;
      overflow      <= 1'b0;
    end else if (accept) begin
      if (last) begin
        wr_bank       <= !wr_bank;
        fill_count    <= '0;
        base_length   <= '0;
        ext_length    <= '0;
        dot_count     <= '0;
        saw_upper     <= 1'b0;
        saw_lower     <= 1'b0;
        bad_char_seen <= 1'b0;
        overflow      <= 1'b0;
      end else begin
        fill_count    <= fill_count_next;
        base_length   <= base_length_next;
        ext_length    <= ext_length_next;
        dot_count     <= dot_count_next;
        saw_upper     <= saw_upper_next;
        saw_lower     <= saw_lower_next;
        bad_char_seen <= bad_char_seen_next;
        overflow      <= overflow_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/dsc_name_ram.sv
// ----------------------------------------------------------------------------
// dsc_name_ram
// Two-bank name buffer, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_name_ram #(
  parameter int AW = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/dsc_info_fifo.sv
// ----------------------------------------------------------------------------
// dsc_info_fifo
// Two-entry queue of finished-name descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_info_fifo
  import dsc_pkg::*;
#(
  parameter int LW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire name_info_t    push_info,
  input  wire logic [LW-1:0] push_len,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output name_info_t         head_info,
  output logic [LW-1:0]      head_len
);

  name_info_t    info_q [2];
  logic [LW-1:0] len_q  [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full      = count == 2'd2;
  assign empty     = count == 2'd0;
  assign head_info = info_q[rd_ptr];
  assign head_len  = len_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      info_q[wr_ptr] <= push_info;
      len_q[wr_ptr]  <= push_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: design/dsc_back.sv
// ----------------------------------------------------------------------------
// dsc_back
// Reads the queued name out of its bank, applies the case mode and drives
// one result per character.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_back
  import dsc_pkg::*;
#(
  parameter int IW = 6,
  parameter int LW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire name_info_t    head_info,
  input  wire logic [LW-1:0] head_len,
  input  wire logic [7:0]    rd_data,
  input  wire logic [1:0]    short_case_mode,
  input  wire logic [1:0]    long_case_mode,
  output logic               pop,
  output logic [IW:0]        rd_addr,
  output logic               out_valid,
  output logic [7:0]         out_ch,
  output logic               out_last,
  output logic               is_short_name,
  output logic               truncated
);

  logic [IW-1:0] rd_idx;
  logic          issue;
  logic          is_end;
  logic          s1_valid;
  logic          s1_last;
  logic          s1_short;
  logic          s1_trunc;

  assign issue   = !q_empty;
  assign is_end  = (LW'(rd_idx) + LW'(1)) == head_len;
  assign pop     = issue && is_end;
  assign rd_addr = {head_info.bank, rd_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) rd_idx <= is_end ? '0 : rd_idx + IW'(1);
      s1_valid  <= issue;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_last       <= is_end;
    s1_short      <= head_info.is_short;
    s1_trunc      <= head_info.trunc;
    out_ch        <= convert_case(rd_data, s1_short ? short_case_mode : long_case_mode);
    out_last      <= s1_last;
    is_short_name <= s1_short;
    truncated     <= s1_trunc;
  end

endmodule

`default_nettype wire

FILE: tb/dos_short_name_case_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dos_short_name_case_converter_top_tb
// Self-checking bench for the DOS 8.3 name check and case converter.
// A directed table of single-character and short names runs first, then
// random names (well-formed 8.3 names, mixed case, over-long parts, extra
// dots, bad bytes, names at and past the buffer size) under a series of
// case-mode settings. Every emitted character is compared with a local
// model of the name check and case conversion.
// ----------------------------------------------------------------------------
module dos_short_name_case_converter_top_tb;
  import dsc_pkg::*;

  localparam int NAME_DEPTH = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 45;
  localparam int NUM_PHASES = 8;

  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_KEEP_ALT = 2'd3;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] c;
    logic       lst;
    logic       short_n;
    logic       trunc;
  } emit_t;

  typedef struct packed {
    logic [7:0] c;
    logic       lst;
    logic       typed;
    logic [7:0] e_c;
    logic       e_short;
  } row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] ch;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [1:0] cfg_data;
  logic       out_valid;
  logic [7:0] out_ch;
  logic       out_last;
  logic       is_short_name;
  logic       truncated;

  // model state
  logic [7:0] name_chars [NAME_DEPTH];
  logic [6:0] fill_cnt;
  logic [3:0] base_len;
  logic [2:0] ext_len;
  logic [1:0] dot_cnt;
  logic       seen_up, seen_lo, seen_bad, dropped;
  logic [1:0] short_mode, long_mode;

  emit_t      expected_chars [$];
  row_t       dir_rows [$];
  logic [7:0] name_q [$];
  int         errors = 0;
  int         stall_cnt = 0;
  bit         idle_on;

  dos_short_name_case_converter_top #(.MAX_NAME(NAME_DEPTH)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ch(ch), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_ch(out_ch),
    .out_last(out_last), .is_short_name(is_short_name), .truncated(truncated)
  );

  always #2 clk = ~clk;

  function automatic logic up_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5a]};
  endfunction

  function automatic logic lo_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7a]};
  endfunction

  function automatic logic [7:0] punct_at(input int i);
    case (i)
      0: return 8'h21;  1: return 8'h40;  2: return 8'h23;  3: return 8'h24;
      4: return 8'h25;  5: return 8'h5e;  6: return 8'h26;  7: return 8'h28;
      8: return 8'h29;  9: return 8'h7e;  10: return 8'h60; 11: return 8'h27;
      12: return 8'h2d; 13: return 8'h5f; 14: return 8'h7b; default: return 8'h7d;
    endcase
  endfunction

  function automatic logic legal_char(input logic [7:0] c);
    int i;
    if (up_letter(c) || lo_letter(c) || c inside {[8'h30:8'h39]} || c == CHAR_DOT) begin
      return 1'b1;
    end
    for (i = 0; i < 16; i++) begin
      if (punct_at(i) == c) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c, input logic [1:0] mode);
    case (mode)
      MODE_UPPER: return lo_letter(c) ? c - CASE_DELTA : c;
      MODE_LOWER: return up_letter(c) ? c + CASE_DELTA : c;
      default: return c;
    endcase
  endfunction

  // cs: 0 upper letters, 1 lower letters, 2 no letters, 3 either case
  function automatic logic [7:0] pick_char(input int cs);
    int r;
    r = (cs == 2) ? $urandom_range(26, 51) : $urandom_range(0, 51);
    if (r < 26) begin
      if (cs == 1 || (cs == 3 && $urandom_range(0, 1) == 1)) begin
        return 8'h61 + r[7:0];
      end
      return 8'h41 + r[7:0];
    end
    if (r < 36) begin
      return 8'h30 + r[7:0] - 8'd26;
    end
    return punct_at(r - 36);
  endfunction

  function automatic row_t mk_row(input logic [7:0] c, input logic l, input logic t,
                                  input logic [7:0] ec, input logic es);
    row_t r;
    r.c = c;
    r.lst = l;
    r.typed = t;
    r.e_c = ec;
    r.e_short = es;
    return r;
  endfunction

  task automatic clear_name();
    fill_cnt = '0;
    base_len = '0;
    ext_len = '0;
    dot_cnt = '0;
    seen_up = 1'b0;
    seen_lo = 1'b0;
    seen_bad = 1'b0;
    dropped = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] c, input logic l);
    emit_t e;
    logic sh;
    logic [1:0] m;
    int i;
    if (!legal_char(c)) begin
      seen_bad = 1'b1;
    end else if (c == CHAR_DOT) begin
      if (dot_cnt < 2) dot_cnt++;
    end else begin
      if (dot_cnt == 0) begin
        if (base_len < 9) base_len++;
      end else begin
        if (ext_len < 4) ext_len++;
      end
      if (up_letter(c)) seen_up = 1'b1;
      else if (lo_letter(c)) seen_lo = 1'b1;
    end
    if (fill_cnt < NAME_DEPTH) begin
      name_chars[fill_cnt[5:0]] = c;
      fill_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (l) begin
      sh = !seen_bad && dot_cnt < 2 && ext_len < 4 && base_len < 9 && !(seen_up && seen_lo);
      m = sh ? short_mode : long_mode;
      for (i = 0; i < fill_cnt; i++) begin
        e.c = fold_case(name_chars[i[5:0]], m);
        e.lst = (i + 1 == fill_cnt);
        e.short_n = sh;
        e.trunc = dropped;
        expected_chars.push_back(e);
      end
      clear_name();
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic l);
    int gaps;
    gaps = 0;
    if (idle_on) begin
      while ($urandom_range(0, 99) < 37 && gaps < 8) begin
        start <= 1'b0;
        @(posedge clk);
        gaps++;
      end
    end
    start <= 1'b1;
    ch <= c;
    last <= l;
    do @(posedge clk); while (busy);
    take_char(c, l);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SHORT_MODE) short_mode = val;
    else if (idx == CFG_LONG_MODE) long_mode = val;
  endtask

  task automatic drain(input int settle);
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  always @(posedge clk) begin
    emit_t e;
    if (!rst && out_valid) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_ch %h out_last %b", out_ch, out_last);
        errors++;
      end else begin
        e = expected_chars.pop_front();
        if (out_ch !== e.c) begin
          $error("out_ch: expected %h, actual %h", e.c, out_ch);
          errors++;
        end
        if (out_last !== e.lst) begin
          $error("out_last: expected %b, actual %b", e.lst, out_last);
          errors++;
        end
        if (is_short_name !== e.short_n) begin
          $error("is_short_name: expected %b, actual %b", e.short_n, is_short_name);
          errors++;
        end
        if (truncated !== e.trunc) begin
          $error("truncated: expected %b, actual %b", e.trunc, truncated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int p, i, k, n, kind, cs, sent, pos;
    row_t r;
    emit_t e;
    bit big_done;
    logic [1:0] s_set [NUM_PHASES];
    logic [1:0] l_set [NUM_PHASES];

    rst = 1'b1;
    start = 1'b0;
    ch = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    short_mode = MODE_KEEP;
    long_mode = MODE_KEEP;
    clear_name();
    idle_on = 1'b1;

    s_set = '{MODE_UPPER, MODE_LOWER, MODE_KEEP_ALT, MODE_UPPER,
              MODE_LOWER, MODE_KEEP, MODE_KEEP_ALT, MODE_LOWER};
    l_set = '{MODE_LOWER, MODE_UPPER, MODE_KEEP_ALT, MODE_UPPER,
              MODE_LOWER, MODE_KEEP_ALT, MODE_KEEP, MODE_KEEP};

    dir_rows.push_back(mk_row("a", 1'b1, 1'b1, "a", 1'b1));
    dir_rows.push_back(mk_row("Z", 1'b1, 1'b1, "Z", 1'b1));
    dir_rows.push_back(mk_row(".", 1'b1, 1'b1, ".", 1'b1));
    dir_rows.push_back(mk_row("~", 1'b1, 1'b1, "~", 1'b1));
    dir_rows.push_back(mk_row("0", 1'b1, 1'b1, "0", 1'b1));
    dir_rows.push_back(mk_row(8'hff, 1'b1, 1'b1, 8'hff, 1'b0));
    dir_rows.push_back(mk_row(8'h01, 1'b1, 1'b1, 8'h01, 1'b0));
    dir_rows.push_back(mk_row(8'h80, 1'b1, 1'b1, 8'h80, 1'b0));
    dir_rows.push_back(mk_row(8'h7f, 1'b1, 1'b1, 8'h7f, 1'b0));
    // mixed case
    dir_rows.push_back(mk_row("a", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("B", 1'b1, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("A", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("B", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(".", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("C", 1'b1, 1'b0, 8'h00, 1'b0));
    // two dots
    dir_rows.push_back(mk_row("x", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(".", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(".", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("y", 1'b1, 1'b0, 8'h00, 1'b0));
    // four-character extension
    dir_rows.push_back(mk_row("a", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(".", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("b", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("c", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("d", 1'b0, 1'b0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row("e", 1'b1, 1'b0, 8'h00, 1'b0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_item(r.c, r.lst);
      if (r.typed) begin
        e = expected_chars.pop_back();
        e.c = r.e_c;
        e.lst = 1'b1;
        e.short_n = r.e_short;
        e.trunc = 1'b0;
        expected_chars.push_back(e);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain(10);
      write_reg(CFG_SHORT_MODE, s_set[p]);
      write_reg(CFG_LONG_MODE, l_set[p]);
      if (p == 2 || p == 5) begin
        write_reg(CFG_SPARE_A, 2'($urandom_range(0, 3)));
        write_reg(CFG_SPARE_B, 2'($urandom_range(0, 3)));
      end
      cfg_valid <= 1'b0;
      @(posedge clk);
      idle_on = (p != 3);
      big_done = (p != 1 && p != 6);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        name_q.delete();
        kind = $urandom_range(0, 99);
        cs = $urandom_range(0, 2);
        if (!big_done) begin
          big_done = 1'b1;
          n = (p == 1) ? NAME_DEPTH : NAME_DEPTH + 3;
          for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
        end else if (kind < 45 || (kind >= 85 && kind < 95)) begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
          if ($urandom_range(0, 3) != 0) begin
            name_q.push_back(CHAR_DOT);
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
          end
          if (kind >= 85) begin
            pos = $urandom_range(0, name_q.size() - 1);
            name_q[pos] = 8'($urandom_range(1, 255));
          end
        end else if (kind < 55) begin
          name_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
          name_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
          n = $urandom_range(0, 6);
          for (k = 0; k < n; k++) name_q.push_back(pick_char(3));
          if ($urandom_range(0, 1) == 1) begin
            name_q.shuffle();
          end
        end else if (kind < 65) begin
          if ($urandom_range(0, 1) == 1) begin
            n = $urandom_range(9, 14);
            for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
          end else begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
            name_q.push_back(CHAR_DOT);
            n = $urandom_range(4, 6);
            for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
          end
        end else if (kind < 73) begin
          n = $urandom_range(0, 4);
          for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
          name_q.push_back(CHAR_DOT);
          n = $urandom_range(0, 3);
          for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
          name_q.push_back(CHAR_DOT);
          n = $urandom_range(0, 3);
          for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
        end else if (kind < 85) begin
          n = $urandom_range(1, 12);
          for (k = 0; k < n; k++) name_q.push_back(8'($urandom_range(1, 255)));
        end else begin
          n = $urandom_range(60, 70);
          for (k = 0; k < n; k++) name_q.push_back(pick_char(cs));
        end
        foreach (name_q[k]) begin
          send_item(name_q[k], k == name_q.size() - 1);
        end
        sent += name_q.size();
      end
    end

    idle_on = 1'b1;
    drain(80);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dsc_pkg.sv
design/dsc_front.sv
design/dsc_name_ram.sv
design/dsc_info_fifo.sv
design/dsc_back.sv
design/dos_short_name_case_converter_top.sv
tb/dos_short_name_case_converter_top_tb.sv
